// File: sv/ppmfd_pkg.sv
package ppmfd_pkg;

   localparam int unsigned MAX_CHANNELS_DEF = 12;

   // Extended timestamps and intervals are 32 bits; one timer period is 2^16 counts.
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned CAPTURE_W    = 16;
   localparam int unsigned DIVISOR_W    = 8;
   localparam int unsigned PERIOD_W     = 17;
   localparam int unsigned WIDTH_W      = 16;
   localparam int unsigned STABLE_W     = 5;
   localparam int unsigned MIN_CH_W     = 4;
   localparam int unsigned CHAN_IDX_W   = 4;
   localparam int unsigned FRAME_W      = 8;
   localparam logic [TIME_W-1:0] TIMER_PERIOD = 32'h0001_0000;
   localparam logic [CAPTURE_W-1:0] CAPTURE_MAX = 16'hFFFF;

   // Configuration register map.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_DIVISOR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_MIN_GAP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MIN_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MAX_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_FRAMES    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CHANNEL_CNT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_CODE     = 3'd6;

   localparam logic [DIVISOR_W-1:0] COUNT_DIVISOR_RST   = 8'd1;
   localparam logic [WIDTH_W-1:0]   SYNC_MIN_GAP_RST    = 16'd2700;
   localparam logic [WIDTH_W-1:0]   PULSE_MIN_WIDTH_RST = 16'd750;
   localparam logic [WIDTH_W-1:0]   PULSE_MAX_WIDTH_RST = 16'd2250;
   localparam logic [STABLE_W-1:0]  STABLE_FRAMES_RST   = 5'd25;
   localparam logic [MIN_CH_W-1:0]  MIN_CHANNEL_CNT_RST = 4'd4;
   localparam logic [WIDTH_W-1:0]   TIMEOUT_CODE_RST    = 16'd0;

   // Input event kinds.
   localparam logic KIND_OVERFLOW = 1'b0;
   localparam logic KIND_EDGE     = 1'b1;

   typedef logic [TIME_W-1:0] time_type;

endpackage

// File: sv/ppm_frame_decoder_unit.sv
// PPM sum-signal decoder. A timer overflow transaction is absorbed without a stall. An
// edge transaction holds req_stall high through these steps: the extended timestamp and
// the timer period go through a serial 32-step divider (one quotient bit per cycle),
// the divider's completion is registered, and the interval is then formed and
// classified in the S_DIFF, S_DELTA and S_EVAL states.
// A sync gap that completes a well-formed frame adds MAX_CHANNELS result transactions;
// each slot is read from the width memory, which has separate read and write ports, in
// S_RD before it is presented in S_OUT, where rsp_stall can hold it. One item is in
// work at a time; req_stall is low only when idle. The width memory needs no clearing
// pass: a frame only reports slots written during it.
module ppm_frame_decoder_unit
   import ppmfd_pkg::*;
#(
   parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [CAPTURE_W-1:0]   req_capture,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAN_IDX_W-1:0]  rsp_channel_index,
   output logic [WIDTH_W-1:0]     rsp_pulse_width,
   output logic [FRAME_W-1:0]     rsp_frame_number,
   output logic                   rsp_last,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(MAX_CHANNELS);
   // One extra bit so that all ones never equals a real channel count.
   localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1) + 1;
   localparam logic [CNT_W-1:0] CNT_NONE = '1;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHANNELS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CHANNELS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_DIFF  = 3'd2;
   localparam logic [2:0] S_DELTA = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_RD    = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // Configuration registers.
   logic [DIVISOR_W-1:0] count_divisor_ff;
   logic [WIDTH_W-1:0]   sync_min_gap_ff;
   logic [WIDTH_W-1:0]   pulse_min_width_ff;
   logic [WIDTH_W-1:0]   pulse_max_width_ff;
   logic [STABLE_W-1:0]  stable_frames_ff;
   logic [MIN_CH_W-1:0]  min_channel_cnt_ff;
   logic [WIDTH_W-1:0]   timeout_code_ff;

   logic [2:0]           state_ff, state_in;
   time_type             time_base_ff, time_base_in;
   logic                 wrap_seen_ff, wrap_seen_in;
   logic [CAPTURE_W-1:0] last_raw_ff, last_raw_in;
   time_type             last_edge_ff, last_edge_in;
   logic [CNT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]     locked_ff, locked_in;
   logic [CNT_W-1:0]     prev_frame_ff, prev_frame_in;
   logic [STABLE_W-1:0]  stable_run_ff, stable_run_in;
   logic                 in_frame_ff, in_frame_in;
   logic [FRAME_W-1:0]   frames_done_ff, frames_done_in;
   time_type             diff_ff, diff_in;
   logic                 later_ff, later_in;
   time_type             delta_ff, delta_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 req_accept;
   logic                 div_start;
   logic                 div_done;
   logic [DIVISOR_W-1:0] div_eff;
   time_type             now_raw;
   time_type             now_div;
   logic [PERIOD_W-1:0]  period_div;
   logic                 wrap_adjust;
   logic [TIME_W:0]      diff_wide;
   time_type             delta_adj;
   logic                 is_sync;
   logic                 width_ok;
   logic                 frame_same;
   logic [CNT_W-1:0]     locked_next;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [WIDTH_W-1:0]   mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_divisor_ff   <= COUNT_DIVISOR_RST;
         sync_min_gap_ff    <= SYNC_MIN_GAP_RST;
         pulse_min_width_ff <= PULSE_MIN_WIDTH_RST;
         pulse_max_width_ff <= PULSE_MAX_WIDTH_RST;
         stable_frames_ff   <= STABLE_FRAMES_RST;
         min_channel_cnt_ff <= MIN_CHANNEL_CNT_RST;
         timeout_code_ff    <= TIMEOUT_CODE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COUNT_DIVISOR:   count_divisor_ff   <= csr_wr_data[DIVISOR_W-1:0];
            CSR_SYNC_MIN_GAP:    sync_min_gap_ff    <= csr_wr_data;
            CSR_PULSE_MIN_WIDTH: pulse_min_width_ff <= csr_wr_data;
            CSR_PULSE_MAX_WIDTH: pulse_max_width_ff <= csr_wr_data;
            CSR_STABLE_FRAMES:   stable_frames_ff   <= csr_wr_data[STABLE_W-1:0];
            CSR_MIN_CHANNEL_CNT: min_channel_cnt_ff <= csr_wr_data[MIN_CH_W-1:0];
            CSR_TIMEOUT_CODE:    timeout_code_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign div_eff    = (count_divisor_ff == '0) ? DIVISOR_W'(1) : count_divisor_ff;

   // The raw count went backwards after a wrap: the capture belongs to the next period.
   assign wrap_adjust = (req_capture < last_raw_ff) && wrap_seen_ff;
   assign now_raw     = time_base_ff + {15'd0, wrap_adjust, req_capture};
   assign div_start   = req_accept && (req_kind == KIND_EDGE);

   assign diff_wide = {1'b0, now_div} - {1'b0, last_edge_ff};

   always_comb begin
      if (later_ff) begin
         delta_adj = wrap_seen_ff ? (TIME_W'(0) - TIME_W'(period_div)) : '0;
      end else begin
         delta_adj = TIME_W'(period_div);
      end
   end

   assign is_sync  = delta_ff > TIME_W'(sync_min_gap_ff);
   assign width_ok = (delta_ff > TIME_W'(pulse_min_width_ff))
                     && (delta_ff < TIME_W'(pulse_max_width_ff))
                     && (slot_ff < CNT_MAX);
   assign frame_same = (slot_ff == prev_frame_ff)
                       && (slot_ff >= CNT_W'(min_channel_cnt_ff))
                       && (slot_ff <= CNT_MAX);
   assign locked_next = (frame_same && (stable_run_ff >= stable_frames_ff)) ? slot_ff
                                                                             : locked_ff;

   assign mem_wr_en = (state_ff == S_EVAL) && !is_sync && in_frame_ff && width_ok;
   assign mem_rd_en = (state_ff == S_RD);

   always_comb begin
      state_in       = state_ff;
      time_base_in   = time_base_ff;
      wrap_seen_in   = wrap_seen_ff;
      last_raw_in    = last_raw_ff;
      last_edge_in   = last_edge_ff;
      slot_in        = slot_ff;
      locked_in      = locked_ff;
      prev_frame_in  = prev_frame_ff;
      stable_run_in  = stable_run_ff;
      in_frame_in    = in_frame_ff;
      frames_done_in = frames_done_ff;
      diff_in        = diff_ff;
      later_in       = later_ff;
      delta_in       = delta_ff;
      idx_in         = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_OVERFLOW) begin
                  time_base_in = time_base_ff + TIME_W'(req_capture) + TIME_W'(1);
                  if (req_capture == CAPTURE_MAX) begin
                     wrap_seen_in = 1'b1;
                  end
               end else begin
                  last_raw_in = req_capture;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in      = diff_wide[TIME_W-1:0];
            later_in     = !diff_wide[TIME_W] && (diff_wide[TIME_W-1:0] != '0);
            last_edge_in = now_div;
            state_in     = S_DELTA;
         end
         S_DELTA: begin
            delta_in     = diff_ff + delta_adj;
            wrap_seen_in = 1'b0;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (is_sync) begin
               if (frame_same) begin
                  if (stable_run_ff < stable_frames_ff) begin
                     stable_run_in = stable_run_ff + 1'b1;
                  end
               end else begin
                  stable_run_in = '0;
               end
               locked_in = locked_next;
               if (in_frame_ff && (slot_ff == locked_next)) begin
                  frames_done_in = frames_done_ff + 1'b1;
                  idx_in         = '0;
                  state_in       = S_RD;
               end
               in_frame_in   = 1'b1;
               prev_frame_in = slot_ff;
               slot_in       = '0;
            end else if (in_frame_ff) begin
               if (width_ok) begin
                  slot_in = slot_ff + 1'b1;
               end else begin
                  // The stored widths are not read again before rewritten.
                  in_frame_in = 1'b0;
               end
            end
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == IDX_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         time_base_ff   <= '0;
         wrap_seen_ff   <= 1'b0;
         last_raw_ff    <= '0;
         last_edge_ff   <= '0;
         slot_ff        <= '0;
         locked_ff      <= CNT_NONE;
         prev_frame_ff  <= CNT_NONE;
         stable_run_ff  <= '0;
         in_frame_ff    <= 1'b0;
         frames_done_ff <= '0;
         idx_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         time_base_ff   <= time_base_in;
         wrap_seen_ff   <= wrap_seen_in;
         last_raw_ff    <= last_raw_in;
         last_edge_ff   <= last_edge_in;
         slot_ff        <= slot_in;
         locked_ff      <= locked_in;
         prev_frame_ff  <= prev_frame_in;
         stable_run_ff  <= stable_run_in;
         in_frame_ff    <= in_frame_in;
         frames_done_ff <= frames_done_in;
         idx_ff         <= idx_in;
      end
      diff_ff  <= diff_in;
      later_ff <= later_in;
      delta_ff <= delta_in;
   end

   ppmfd_divider u_divider (
      .clock           (clock),
      .reset           (reset),
      .start           (div_start),
      .dividend        (now_raw),
      .divisor         (div_eff),
      .done            (div_done),
      .quotient        (now_div),
      .period_quotient (period_div)
   );

   ppmfd_width_store #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (IDX_W)
   ) u_width_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (slot_ff[IDX_W-1:0]),
      .wr_data (delta_ff[WIDTH_W-1:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data)
   );

   // Slots beyond the locked count report the timeout code.
   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_channel_index = CHAN_IDX_W'(idx_ff);
   assign rsp_pulse_width   = (CNT_W'(idx_ff) < locked_ff) ? mem_rd_data : timeout_code_ff;
   assign rsp_frame_number  = frames_done_ff;
   assign rsp_last          = (idx_ff == IDX_LAST);

endmodule

// File: sv/ppmfd_divider.sv
module ppmfd_divider
   import ppmfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  time_type               dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output logic                   done,
   output time_type               quotient,
   output logic [PERIOD_W-1:0]    period_quotient
);

   localparam int unsigned STEPS = TIME_W;
   localparam int unsigned CNT_W = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   time_type             quo_a_ff, quo_a_in;
   time_type             quo_b_ff, quo_b_in;
   logic [DIVISOR_W-1:0] rem_a_ff, rem_a_in;
   logic [DIVISOR_W-1:0] rem_b_ff, rem_b_in;

   logic [DIVISOR_W:0]   shift_a, shift_b;
   logic                 ge_a, ge_b;

   // Two restoring lanes share the divisor: the timestamp and one timer period.
   always_comb begin
      shift_a = {rem_a_ff, quo_a_ff[TIME_W-1]};
      shift_b = {rem_b_ff, quo_b_ff[TIME_W-1]};
      ge_a    = shift_a >= {1'b0, div_ff};
      ge_b    = shift_b >= {1'b0, div_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(STEPS - 1);
         div_in   = divisor;
         quo_a_in = dividend;
         quo_b_in = TIMER_PERIOD;
         rem_a_in = '0;
         rem_b_in = '0;
      end else if (busy_ff) begin
         quo_a_in = {quo_a_ff[TIME_W-2:0], ge_a};
         quo_b_in = {quo_b_ff[TIME_W-2:0], ge_b};
         rem_a_in = ge_a ? DIVISOR_W'(shift_a - {1'b0, div_ff}) : shift_a[DIVISOR_W-1:0];
         rem_b_in = ge_b ? DIVISOR_W'(shift_b - {1'b0, div_ff}) : shift_b[DIVISOR_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff   <= div_in;
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
   end

   assign done            = done_ff;
   assign quotient        = quo_a_ff;
   assign period_quotient = quo_b_ff[PERIOD_W-1:0];

endmodule

// File: sv/ppmfd_width_store.sv
module ppmfd_width_store
   import ppmfd_pkg::*;
#(
   parameter int unsigned DEPTH  = MAX_CHANNELS_DEF,
   parameter int unsigned ADDR_W = $clog2(MAX_CHANNELS_DEF)
)(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [WIDTH_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [WIDTH_W-1:0] rd_data
);

   logic [WIDTH_W-1:0] mem [DEPTH];
   logic [WIDTH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/tb_ppm_frame_decoder_unit.sv
`timescale 1ns / 1ps

module tb_ppm_frame_decoder_unit;
   import ppmfd_pkg::*;

   localparam int NUM_SLOTS = MAX_CHANNELS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD = 500;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic                 kind;
      logic [CAPTURE_W-1:0] capture;
   } timer_event_type;

   typedef struct packed {
      logic [CHAN_IDX_W-1:0] slot;
      logic [WIDTH_W-1:0]    width;
      logic [FRAME_W-1:0]    frame;
      logic                  is_last;
   } channel_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_kind = KIND_OVERFLOW;
   logic [CAPTURE_W-1:0]   req_capture = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAN_IDX_W-1:0]  rsp_channel_index;
   logic [WIDTH_W-1:0]     rsp_pulse_width;
   logic [FRAME_W-1:0]     rsp_frame_number;
   logic                   rsp_last;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   ppm_frame_decoder_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_capture       (req_capture),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_pulse_width   (rsp_pulse_width),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register copies used by the decoder model and the frame generator.
   logic [DIVISOR_W-1:0] cfg_div;
   logic [WIDTH_W-1:0]   cfg_sync;
   logic [WIDTH_W-1:0]   cfg_min_w;
   logic [WIDTH_W-1:0]   cfg_max_w;
   logic [STABLE_W-1:0]  cfg_stable;
   logic [MIN_CH_W-1:0]  cfg_min_ch;
   logic [WIDTH_W-1:0]   cfg_timeout;

   // Decoder model state.
   logic [TIME_W-1:0]    dec_base;
   logic                 dec_wrapped;
   logic [CAPTURE_W-1:0] dec_prev_raw;
   logic [TIME_W-1:0]    dec_prev_edge;
   int                   dec_slot;
   int                   dec_locked;
   int                   dec_prior;
   int                   dec_stable;
   logic                 dec_tracking;
   logic [WIDTH_W-1:0]   dec_widths [NUM_SLOTS];
   logic [FRAME_W-1:0]   dec_frames;

   timer_event_type    pending_events [$];
   channel_report_type expected_reports [$];
   timer_event_type    next_event;
   channel_report_type got_report;

   int unsigned gen_timer = 0;
   bit          gen_wraps = 1'b1;
   int          phase_items = 0;
   bit          idle_calm = 1'b0;

   int unsigned tx_gap = 0;
   int unsigned rx_left = 0;
   int unsigned rx_gap;
   int unsigned hold_cycles = 0;
   int          holds_requested = 0;
   int          holds_served = 0;

   int mismatch_count = 0;
   int events_accepted = 0;
   int edges_decoded = 0;
   int frames_decoded = 0;
   int reports_checked = 0;
   int settings_used = 0;
   int cycle_count = 0;

   function automatic void reset_decoder();
      cfg_div = COUNT_DIVISOR_RST;
      cfg_sync = SYNC_MIN_GAP_RST;
      cfg_min_w = PULSE_MIN_WIDTH_RST;
      cfg_max_w = PULSE_MAX_WIDTH_RST;
      cfg_stable = STABLE_FRAMES_RST;
      cfg_min_ch = MIN_CHANNEL_CNT_RST;
      cfg_timeout = TIMEOUT_CODE_RST;
      dec_base = '0;
      dec_wrapped = 1'b0;
      dec_prev_raw = '0;
      dec_prev_edge = '0;
      dec_slot = 0;
      dec_locked = -1;
      dec_prior = -1;
      dec_stable = 0;
      dec_tracking = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) dec_widths[i] = '0;
      dec_frames = '0;
   endfunction

   // Advances the decoder model by one accepted timer event and queues the
   // channel reports that a completed frame produces.
   function automatic void decode_event(logic kind, logic [CAPTURE_W-1:0] cap);
      logic [TIME_W-1:0]  div;
      logic [TIME_W-1:0]  period_div;
      logic [TIME_W-1:0]  now;
      logic [TIME_W-1:0]  delta;
      channel_report_type rep;
      if (kind == KIND_OVERFLOW) begin
         dec_base = dec_base + {16'd0, cap} + 32'd1;
         if (cap == CAPTURE_MAX) dec_wrapped = 1'b1;
         return;
      end
      edges_decoded++;
      div = (cfg_div == '0) ? 32'd1 : {24'd0, cfg_div};
      period_div = TIMER_PERIOD / div;
      now = {16'd0, cap} + dec_base;
      if (cap < dec_prev_raw && dec_wrapped) now = now + TIMER_PERIOD;
      now = now / div;
      if (now > dec_prev_edge) begin
         delta = now - (dec_prev_edge + (dec_wrapped ? period_div : 32'd0));
      end else begin
         delta = period_div + now - dec_prev_edge;
      end
      dec_wrapped = 1'b0;
      dec_prev_edge = now;
      dec_prev_raw = cap;

      if (delta > {16'd0, cfg_sync}) begin
         if (dec_slot == dec_prior && dec_slot >= int'(cfg_min_ch)
             && dec_slot <= NUM_SLOTS) begin
            if (dec_stable < int'(cfg_stable)) dec_stable++;
            else dec_locked = dec_slot;
         end else begin
            dec_stable = 0;
         end
         if (dec_slot == dec_locked && dec_tracking) begin
            dec_frames = dec_frames + 8'd1;
            frames_decoded++;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               rep.slot = i[CHAN_IDX_W-1:0];
               rep.width = (i < dec_locked) ? dec_widths[i] : cfg_timeout;
               rep.frame = dec_frames;
               rep.is_last = (i == NUM_SLOTS - 1);
               expected_reports.push_back(rep);
            end
         end
         dec_tracking = 1'b1;
         dec_prior = dec_slot;
         dec_slot = 0;
      end else if (dec_tracking) begin
         if (delta > {16'd0, cfg_min_w} && delta < {16'd0, cfg_max_w}
             && dec_slot < NUM_SLOTS) begin
            dec_widths[dec_slot] = delta[WIDTH_W-1:0];
            dec_slot++;
         end else begin
            // A bad pulse or one slot too many drops tracking for this frame.
            dec_tracking = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) dec_widths[i] = cfg_timeout;
         end
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (idle_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Stimulus generation: a free-running 16-bit timer that produces edge
   // transactions at chosen intervals and, optionally, overflow transactions.
   function automatic void push_event(logic kind, logic [CAPTURE_W-1:0] cap);
      timer_event_type ev;
      ev.kind = kind;
      ev.capture = cap;
      pending_events.push_back(ev);
      phase_items++;
   endfunction

   function automatic int unsigned eff_div();
      return (cfg_div == '0) ? 1 : int'(cfg_div);
   endfunction

   function automatic void step_timer(int unsigned raw);
      int unsigned nxt;
      nxt = gen_timer + raw;
      if (nxt > 65535 && gen_wraps) push_event(KIND_OVERFLOW, CAPTURE_MAX);
      gen_timer = nxt % 65536;
      push_event(KIND_EDGE, gen_timer[CAPTURE_W-1:0]);
   endfunction

   function automatic void add_sync();
      int unsigned max_v;
      int unsigned lo;
      int unsigned v;
      max_v = 65535 / eff_div();
      lo = int'(cfg_sync) + 3;
      if (lo >= max_v) v = max_v;
      else v = $urandom_range(lo, (lo + 1500 < max_v) ? lo + 1500 : max_v);
      step_timer(v * eff_div());
   endfunction

   function automatic void add_channel();
      int max_v;
      int lo;
      int hi;
      int v;
      max_v = 65535 / eff_div();
      lo = int'(cfg_min_w) + 2;
      hi = int'(cfg_max_w) - 2;
      if (hi > int'(cfg_sync) - 1) hi = int'(cfg_sync) - 1;
      if (hi > max_v) hi = max_v;
      if (lo <= hi) v = $urandom_range(lo, hi);
      else v = $urandom_range(0, max_v);
      step_timer(v * eff_div());
   endfunction

   function automatic void add_bad_width();
      int max_v;
      int v;
      max_v = 65535 / eff_div();
      if (cfg_min_w != '0 && $urandom_range(0, 1) == 1) begin
         v = $urandom_range(0, int'(cfg_min_w) - 1);
      end else begin
         v = int'(cfg_max_w) + 1;
      end
      if (v > max_v) v = max_v;
      step_timer(v * eff_div());
   endfunction

   function automatic void add_noise();
      logic                 kind;
      logic [CAPTURE_W-1:0] cap;
      kind = 1'($urandom_range(0, 1));
      cap = CAPTURE_W'($urandom_range(0, 65535));
      push_event(kind, cap);
      if (kind == KIND_EDGE) gen_timer = cap;
   endfunction

   function automatic void add_frame(int channels);
      add_sync();
      repeat (channels) add_channel();
   endfunction

   // Mostly well-formed frames of a steady length so that the channel count
   // locks, mixed with length changes, bad pulses, overlong frames and noise.
   function automatic void fill_phase(int target, int lo_ch, int hi_ch);
      int r;
      int channels;
      channels = $urandom_range(lo_ch, hi_ch);
      while (phase_items < target) begin
         r = $urandom_range(0, 99);
         if (r < 6) channels = $urandom_range(lo_ch, hi_ch);
         if (r < 75) begin
            add_frame(channels);
         end else if (r < 85) begin
            add_frame($urandom_range(lo_ch, hi_ch));
         end else if (r < 92) begin
            add_sync();
            repeat ($urandom_range(0, channels)) add_channel();
            add_bad_width();
         end else if (r < 96) begin
            add_frame(NUM_SLOTS + 1);
         end else begin
            add_noise();
         end
      end
      add_sync();
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_COUNT_DIVISOR: cfg_div = value[DIVISOR_W-1:0];
         CSR_SYNC_MIN_GAP: cfg_sync = value;
         CSR_PULSE_MIN_WIDTH: cfg_min_w = value;
         CSR_PULSE_MAX_WIDTH: cfg_max_w = value;
         CSR_STABLE_FRAMES: cfg_stable = value[STABLE_W-1:0];
         CSR_MIN_CHANNEL_CNT: cfg_min_ch = value[MIN_CH_W-1:0];
         CSR_TIMEOUT_CODE: cfg_timeout = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [DIVISOR_W-1:0] div,
                                 input logic [WIDTH_W-1:0] sync,
                                 input logic [WIDTH_W-1:0] min_w,
                                 input logic [WIDTH_W-1:0] max_w,
                                 input logic [STABLE_W-1:0] stable,
                                 input logic [MIN_CH_W-1:0] min_ch,
                                 input logic [WIDTH_W-1:0] timeout_val);
      write_reg(CSR_COUNT_DIVISOR, CSR_DATA_W'(div));
      write_reg(CSR_SYNC_MIN_GAP, sync);
      write_reg(CSR_PULSE_MIN_WIDTH, min_w);
      write_reg(CSR_PULSE_MAX_WIDTH, max_w);
      write_reg(CSR_STABLE_FRAMES, CSR_DATA_W'(stable));
      write_reg(CSR_MIN_CHANNEL_CNT, CSR_DATA_W'(min_ch));
      write_reg(CSR_TIMEOUT_CODE, timeout_val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      settings_used++;
      phase_items = 0;
   endtask

   // Waits until every transaction has been taken and every report has come,
   // then lets an edge with no report finish inside the block.
   task automatic drain();
      while (pending_events.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void check_report(channel_report_type got);
      channel_report_type want;
      reports_checked++;
      if (expected_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected report at cycle %0d: slot %0d width %0d frame %0d last %0b",
                     cycle_count, got.slot, got.width, got.frame, got.is_last);
      end else begin
         want = expected_reports.pop_front();
         if (want.slot != got.slot || want.width != got.width || want.frame != got.frame
             || want.is_last != got.is_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"report mismatch at cycle %0d: expected slot %0d width %0d ",
                         "frame %0d last %0b, got slot %0d width %0d frame %0d last %0b"},
                        cycle_count, want.slot, want.width, want.frame, want.is_last,
                        got.slot, got.width, got.frame, got.is_last);
         end
      end
   endfunction

   // Sender: presents queued timer events, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_event(req_kind, req_capture);
            events_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (tx_gap != 0) begin
               tx_gap <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               next_event = pending_events.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_event.kind;
               req_capture <= next_event.capture;
               tx_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started on request once reports are flowing.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (holds_served < holds_requested && rsp_valid) begin
         hold_cycles <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end
   end

   // Receiver: checks each accepted report and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_report = {rsp_channel_index, rsp_pulse_width, rsp_frame_number, rsp_last};
            check_report(got_report);
         end
         if (rx_left != 0) begin
            rx_left <= rx_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rx_gap = pick_gap();
            rsp_stall <= (rx_gap != 0) || (hold_cycles != 0);
            rx_left <= (rx_gap != 0) ? rx_gap - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d reports outstanding",
                  cycle_count, expected_reports.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset_decoder();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed events under the reset settings: overflow counts at both
      // extremes, edges at both extremes, repeated identical captures and an
      // odd overflow count that shifts the time base.
      push_event(KIND_OVERFLOW, 16'h0000);
      push_event(KIND_EDGE, 16'h0000);
      push_event(KIND_EDGE, CAPTURE_MAX);
      push_event(KIND_OVERFLOW, CAPTURE_MAX);
      push_event(KIND_EDGE, 16'h0000);
      push_event(KIND_EDGE, 16'h0000);
      push_event(KIND_OVERFLOW, 16'h1234);
      push_event(KIND_EDGE, 16'h8000);
      gen_timer = 32'h8000;
      add_frame(4);
      add_frame(5);
      add_sync();
      drain();

      // Reset thresholds with fast locking; the receiver holds off once.
      holds_requested++;
      apply_settings(COUNT_DIVISOR_RST, SYNC_MIN_GAP_RST, PULSE_MIN_WIDTH_RST,
                     PULSE_MAX_WIDTH_RST, 5'd1, MIN_CHANNEL_CNT_RST, TIMEOUT_CODE_RST);
      gen_wraps = 1'b1;
      add_frame(NUM_SLOTS + 1);
      fill_phase(110, 4, NUM_SLOTS);
      drain();

      // Largest divisor, full channel count required, no idling at all.
      idle_calm = 1'b1;
      apply_settings(8'd255, 16'd200, 16'd20, 16'd150, 5'd0, 4'd12, 16'hFFFF);
      fill_phase(60, NUM_SLOTS, NUM_SLOTS);
      drain();

      // A divisor of zero acts as one; frames without channels may lock.
      idle_calm = 1'b0;
      apply_settings(8'd0, SYNC_MIN_GAP_RST, PULSE_MIN_WIDTH_RST, PULSE_MAX_WIDTH_RST,
                     5'd0, 4'd0, 16'h5A5A);
      gen_wraps = 1'b0;
      fill_phase(60, 0, 3);
      drain();

      // Limits at their extremes: no width is valid, and only a gap above 65535 is a sync.
      apply_settings(8'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 5'd31, 4'd12, 16'h0000);
      gen_wraps = 1'b1;
      repeat (12) add_noise();
      fill_phase(30, 4, NUM_SLOTS);
      drain();

      // Wide-open width window with a small divisor and a second long hold.
      holds_requested++;
      apply_settings(8'd3, 16'd3000, 16'h0000, 16'hFFFF, 5'd2, 4'd1, 16'h8001);
      gen_wraps = 1'b0;
      fill_phase(50, 1, NUM_SLOTS);
      gen_wraps = 1'b1;
      fill_phase(100, 1, NUM_SLOTS);
      drain();

      $display("Decoded %0d timer events (%0d edges) under %0d register settings;",
               events_accepted, edges_decoded, settings_used + 1);
      $display("%0d frames completed and %0d channel reports checked, %0d mismatches.",
               frames_decoded, reports_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
